// File: sv/lprs_pkg.sv
// lprs_pkg: shared types and constants for the led panel row scan block
// no dependencies; used by the channel interfaces and the top level

package lprs_pkg;

  // fixed field widths of the request and result items
  localparam int REQ_TYPE_W  = 1;
  localparam int PIXEL_X_W   = 6;
  localparam int PIXEL_Y_W   = 5;
  localparam int COLOR_W     = 3;
  localparam int SCAN_ROW_W  = 4;
  localparam int COLUMN_W    = 6;

  // default panel geometry
  localparam int DEF_PANEL_WIDTH = 64;
  localparam int DEF_HALF_ROWS   = 16;

  // request type codes
  localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 1'b0;
  localparam logic [REQ_TYPE_W-1:0] REQ_SCAN  = 1'b1;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [PIXEL_X_W-1:0]  pixel_x;
    logic [PIXEL_Y_W-1:0]  pixel_y;
    logic [COLOR_W-1:0]    pixel_color;
    logic [SCAN_ROW_W-1:0] scan_row;
  } lprs_req_t;

  typedef struct packed {
    logic [SCAN_ROW_W-1:0] row_address;
    logic [COLUMN_W-1:0]   column_index;
    logic [COLOR_W-1:0]    top_rgb;
    logic [COLOR_W-1:0]    bottom_rgb;
    logic                  latch_last;
  } lprs_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } lprs_state_t;

endpackage

// File: sv/lprs_req_if.sv
// lprs_req_if: valid/ready channel carrying one request item
// depends on lprs_pkg for the payload type

interface lprs_req_if;
  logic                valid;
  logic                ready;
  lprs_pkg::lprs_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/lprs_res_if.sv
// lprs_res_if: valid/ready channel carrying one result item
// depends on lprs_pkg for the payload type

interface lprs_res_if;
  logic                valid;
  logic                ready;
  lprs_pkg::lprs_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/led_panel_row_scan.sv
// led_panel_row_scan: scan side of a 1/16 scan rgb led matrix driver
// depends on lprs_pkg, lprs_req_if and lprs_res_if

// After reset the block runs a clearing pass over its frame store, one
// entry of each half-panel memory per cycle; no request is taken until it
// ends. A pixel write request gives no result; writes off the panel are
// dropped. A scan request for a row pair gives PANEL_WIDTH results, one per
// column, at one per clock while the result side keeps up, and the block
// takes its next request once the last column has been read, while earlier
// results may still be on their way out. The pace is set by the single read
// port of each memory: the upper and lower halves of the panel sit in two
// memories so both pixels of a column come out in the same read. A scan of a
// row pair beyond the panel gives no result. latch_last marks the last
// column of each scan.

module led_panel_row_scan #(
  parameter int PANEL_WIDTH = lprs_pkg::DEF_PANEL_WIDTH,
  parameter int HALF_ROWS   = lprs_pkg::DEF_HALF_ROWS
) (
  input logic        clk,
  input logic        rst,
  lprs_req_if.sink   req_chan,
  lprs_res_if.source res_chan
);

  // geometry of one half-panel memory
  localparam int DEPTH  = HALF_ROWS * PANEL_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int CMP_W  = 10;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;

  // frame store, upper rows and lower rows
  logic [lprs_pkg::COLOR_W-1:0] mem_top [DEPTH];
  logic [lprs_pkg::COLOR_W-1:0] mem_bot [DEPTH];

  lprs_pkg::lprs_state_t state;

  addr_t clr_cnt;
  col_t  col;
  logic [lprs_pkg::SCAN_ROW_W-1:0] scan_row_r;

  // read stage: memory data plus what travels with it
  logic                            rd_valid;
  logic [lprs_pkg::SCAN_ROW_W-1:0] rd_row;
  col_t                            rd_col;
  logic                            rd_last;
  logic [lprs_pkg::COLOR_W-1:0]    rd_top;
  logic [lprs_pkg::COLOR_W-1:0]    rd_bot;

  // output register
  logic                out_valid;
  lprs_pkg::lprs_res_t out_data;

  // request decode
  logic  accept;
  logic  is_write;
  logic  on_panel;
  logic  y_top;
  logic  row_ok;
  logic [CMP_W-1:0] wrow;
  addr_t waddr;

  // pipeline control
  logic  adv;
  logic  issue;
  logic  last;
  addr_t raddr;

  // memory write port
  logic  we_top;
  logic  we_bot;
  addr_t mem_wa;
  logic [lprs_pkg::COLOR_W-1:0] mem_wd;
  logic  clearing;

  assign req_chan.ready = (state == lprs_pkg::ST_IDLE);
  assign accept         = req_chan.valid && req_chan.ready;
  assign is_write       = (req_chan.data.req_type == lprs_pkg::REQ_WRITE);

  // the pixel must land on the panel: x below the width, y below both halves
  assign on_panel = (CMP_W'(req_chan.data.pixel_x) < CMP_W'(PANEL_WIDTH)) &&
                    (CMP_W'(req_chan.data.pixel_y) < CMP_W'(2 * HALF_ROWS));
  assign y_top    = CMP_W'(req_chan.data.pixel_y) < CMP_W'(HALF_ROWS);
  assign row_ok   = CMP_W'(req_chan.data.scan_row) < CMP_W'(HALF_ROWS);

  // row inside its half, then linear address row*width + column
  assign wrow  = y_top ? CMP_W'(req_chan.data.pixel_y)
                       : CMP_W'(req_chan.data.pixel_y) - CMP_W'(HALF_ROWS);
  assign waddr = addr_t'(wrow) * addr_t'(PANEL_WIDTH) + addr_t'(req_chan.data.pixel_x);

  // the whole pipe moves when the output register is free or being emptied
  assign adv   = !out_valid || res_chan.ready;
  assign issue = (state == lprs_pkg::ST_SCAN) && adv;
  assign last  = (col == col_t'(PANEL_WIDTH - 1));
  assign raddr = addr_t'(scan_row_r) * addr_t'(PANEL_WIDTH) + addr_t'(col);

  assign clearing = (state == lprs_pkg::ST_CLEAR);
  assign we_top   = clearing || (accept && is_write && on_panel && y_top);
  assign we_bot   = clearing || (accept && is_write && on_panel && !y_top);
  assign mem_wa   = clearing ? clr_cnt : waddr;
  assign mem_wd   = clearing ? '0 : req_chan.data.pixel_color;

  assign res_chan.valid = out_valid;
  assign res_chan.data  = out_data;

  // frame store: one write and one registered read per half
  always_ff @(posedge clk) begin
    if (we_top) begin
      mem_top[mem_wa] <= mem_wd;
    end
    if (we_bot) begin
      mem_bot[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rd_top <= mem_top[raddr];
      rd_bot <= mem_bot[raddr];
    end
  end

  // sequencer and result pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lprs_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      col       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= rd_valid;
        rd_valid  <= issue;
      end

      unique case (state)
        lprs_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + addr_t'(1);
          if (clr_cnt == addr_t'(DEPTH - 1)) begin
            state <= lprs_pkg::ST_IDLE;
          end
        end
        lprs_pkg::ST_IDLE: begin
          // out-of-range row pairs are dropped without a result
          if (accept && !is_write && row_ok) begin
            col   <= '0;
            state <= lprs_pkg::ST_SCAN;
          end
        end
        lprs_pkg::ST_SCAN: begin
          if (issue) begin
            col <= col + col_t'(1);
            if (last) begin
              state <= lprs_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          state <= lprs_pkg::ST_CLEAR;
        end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_row_r <= req_chan.data.scan_row;
    end
    if (issue) begin
      rd_row  <= scan_row_r;
      rd_col  <= col;
      rd_last <= last;
    end
    if (adv && rd_valid) begin
      out_data.row_address  <= rd_row;
      out_data.column_index <= lprs_pkg::COLUMN_W'(rd_col);
      out_data.top_rgb      <= rd_top;
      out_data.bottom_rgb   <= rd_bot;
      out_data.latch_last   <= rd_last;
    end
  end

endmodule

// File: dv/tb_led_panel_row_scan.sv
`timescale 1ns / 1ps
// tb_led_panel_row_scan: self-checking testbench for the led panel row scan block
// depends on lprs_pkg, lprs_req_if, lprs_res_if and led_panel_row_scan from sv/

module tb_led_panel_row_scan;

  // panel geometry as built by the default parameters of the block
  localparam int PANEL_W = lprs_pkg::DEF_PANEL_WIDTH;
  localparam int HALF    = lprs_pkg::DEF_HALF_ROWS;
  localparam int ROWS    = 2 * HALF;

  // cycles with no request and no result taken before the run is called hung;
  // covers the clearing pass after reset with margin
  localparam int QUIET_LIMIT = 8 * HALF * PANEL_W;

  // shadow frame store plus the queue of column results still owed by the block
  class frame_scoreboard;
    logic [lprs_pkg::COLOR_W-1:0] frame [ROWS][PANEL_W];
    lprs_pkg::lprs_res_t          owed_columns[$];
    int                           errors;

    function new();
      foreach (frame[y, x]) frame[y][x] = '0;
      errors = 0;
    endfunction

    function int pending();
      return owed_columns.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // a write updates the shadow store, a scan of a row pair on the panel
    // queues one result per column read from the store as it stands now
    task note_request(lprs_pkg::lprs_req_t r);
      lprs_pkg::lprs_res_t col_res;
      if (r.req_type == lprs_pkg::REQ_WRITE) begin
        if (r.pixel_x < PANEL_W && r.pixel_y < ROWS)
          frame[r.pixel_y][r.pixel_x] = r.pixel_color;
      end else if (r.scan_row < HALF) begin
        for (int c = 0; c < PANEL_W; c++) begin
          col_res.row_address  = r.scan_row;
          col_res.column_index = lprs_pkg::COLUMN_W'(c);
          col_res.top_rgb      = frame[r.scan_row][c];
          col_res.bottom_rgb   = frame[r.scan_row + HALF][c];
          col_res.latch_last   = (c == PANEL_W - 1);
          owed_columns.push_back(col_res);
        end
      end
    endtask

    task compare_field(string field, logic [7:0] got, logic [7:0] want,
                       lprs_pkg::lprs_res_t ref_item);
      if (got !== want)
        report_mismatch($sformatf("row %0d col %0d %s: got %0h want %0h",
                                  ref_item.row_address, ref_item.column_index,
                                  field, got, want));
    endtask

    task check_result(lprs_pkg::lprs_res_t got);
      lprs_pkg::lprs_res_t want;
      if (owed_columns.size() == 0) begin
        report_mismatch($sformatf("result row %0d col %0d with no scan waiting",
                                  got.row_address, got.column_index));
        return;
      end
      want = owed_columns.pop_front();
      compare_field("row_address", 8'(got.row_address), 8'(want.row_address), want);
      compare_field("column_index", 8'(got.column_index), 8'(want.column_index), want);
      compare_field("top_rgb", 8'(got.top_rgb), 8'(want.top_rgb), want);
      compare_field("bottom_rgb", 8'(got.bottom_rgb), 8'(want.bottom_rgb), want);
      compare_field("latch_last", 8'(got.latch_last), 8'(want.latch_last), want);
    endtask
  endclass

  logic clk;
  logic rst;

  lprs_req_if req_if ();
  lprs_res_if res_if ();

  led_panel_row_scan u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_chan (req_if),
    .res_chan (res_if)
  );

  frame_scoreboard sb = new();

  // percent chance per cycle that each side holds off
  int sender_idle_pct;
  int receiver_stall_pct;
  int quiet_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side: ready is redrawn every falling edge
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // both channels are sampled at the rising edge, before the block's own
  // registers move; requests are noted before results are checked, which is
  // harmless since a scan's columns are fixed when the scan is taken
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready)
      sb.note_request(req_if.data);
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.data);
  end

  // watchdog: any handshake on either side counts as progress
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles with no handshake", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // entered and left at a falling edge; random gaps are put in front of the
  // request, then valid holds until the block takes it
  task send_request(lprs_pkg::lprs_req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // unused fields carry random filler so every bit toggles either way
  function automatic lprs_pkg::lprs_req_t make_write(int x, int y, int color);
    lprs_pkg::lprs_req_t r;
    r             = lprs_pkg::lprs_req_t'($urandom);
    r.req_type    = lprs_pkg::REQ_WRITE;
    r.pixel_x     = lprs_pkg::PIXEL_X_W'(x);
    r.pixel_y     = lprs_pkg::PIXEL_Y_W'(y);
    r.pixel_color = lprs_pkg::COLOR_W'(color);
    return r;
  endfunction

  function automatic lprs_pkg::lprs_req_t make_scan(int row);
    lprs_pkg::lprs_req_t r;
    r          = lprs_pkg::lprs_req_t'($urandom);
    r.req_type = lprs_pkg::REQ_SCAN;
    r.scan_row = lprs_pkg::SCAN_ROW_W'(row);
    return r;
  endfunction

  // corners of both half panels, colour extremes, both ends of the row
  // range, a scan of the cleared screen and an overwrite back to black
  task run_directed();
    lprs_pkg::lprs_req_t all_ones;
    send_request(make_scan(0));
    send_request(make_scan(HALF - 1));
    send_request(make_write(0, 0, 7));
    send_request(make_write(PANEL_W - 1, 0, 1));
    send_request(make_write(0, HALF, 2));
    send_request(make_write(PANEL_W - 1, HALF, 4));
    send_request(make_scan(0));
    send_request(make_write(0, HALF - 1, 3));
    send_request(make_write(PANEL_W - 1, ROWS - 1, 6));
    send_request(make_write(31, HALF - 1, 5));
    send_request(make_write(32, ROWS - 1, 7));
    send_request(make_scan(HALF - 1));
    send_request(make_write(0, 0, 0));
    send_request(make_scan(0));
    // scan with every pixel field bit set, then a write with every payload bit set
    all_ones          = '1;
    all_ones.req_type = lprs_pkg::REQ_SCAN;
    all_ones.scan_row = lprs_pkg::SCAN_ROW_W'(HALF - 1);
    send_request(all_ones);
    all_ones.req_type = lprs_pkg::REQ_WRITE;
    send_request(all_ones);
    send_request(make_scan(HALF - 1));
    send_request(make_write(PANEL_W - 1, ROWS - 1, 0));
    send_request(make_scan(HALF - 1));
  endtask

  // mostly paint a few pixels of one row pair and then scan that pair, so the
  // scans show fresh content; the rest are lone scans and raw random requests
  task run_random(int n_requests);
    lprs_pkg::lprs_req_t raw;
    int sent;
    int row;
    int n_writes;
    sent = 0;
    while (sent < n_requests) begin
      case ($urandom_range(9))
        0: begin
          raw = lprs_pkg::lprs_req_t'($urandom);
          send_request(raw);
          sent++;
        end
        1: begin
          send_request(make_scan($urandom_range(HALF - 1)));
          sent++;
        end
        default: begin
          row      = $urandom_range(HALF - 1);
          n_writes = $urandom_range(1, 5);
          repeat (n_writes)
            send_request(make_write($urandom_range(PANEL_W - 1),
                                    row + ($urandom_range(1) ? HALF : 0),
                                    $urandom_range(7)));
          send_request(make_scan(row));
          sent += n_writes + 1;
        end
      endcase
    end
  endtask

  initial begin
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.data        <= '0;
    sender_idle_pct    = 37;
    receiver_stall_pct = 58;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles less than the receiver stalls
    run_directed();
    run_random(100);

    // roles swapped
    sender_idle_pct    = 58;
    receiver_stall_pct = 37;
    run_random(110);

    // full rate both ways
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random(110);
    req_if.valid <= 1'b0;

    // drain, then keep watching so that any extra results from the block show
    while (sb.pending() != 0) @(posedge clk);
    repeat (PANEL_W + 8) @(posedge clk);

    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
sv/lprs_pkg.sv
sv/lprs_req_if.sv
sv/lprs_res_if.sv
sv/led_panel_row_scan.sv
dv/tb_led_panel_row_scan.sv
